FILE: hw/rtl/wmad_pkg.sv
// Shared types, constants and helper functions for the window contrast block.
package wmad_pkg;

  localparam int PIX_W       = 16;
  localparam int ROW_W       = 16;
  localparam int IMG_W_W     = 13;
  localparam int APER_W      = 3;
  localparam int CFG_W       = 13;
  localparam int IMG_W_RESET = 1024;
  localparam int APER_RESET  = 1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0] row_t;

  localparam row_t ROW_MAX = '1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_APERTURE    = 1'b1
  } reg_idx_t;

  // Per-cycle control handed from the top level to every window cell
  typedef struct packed {
    logic shift;  // take the neighbour's column
    logic adv;    // advance the compare pipeline
  } cell_ctrl_t;

  function automatic pix_t pix_max(pix_t x, pix_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic pix_t abs_diff(pix_t x, pix_t y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

endpackage

FILE: hw/rtl/wmad_if.sv
// Valid/ready channel interfaces for pixel beats and contrast result beats.
interface wmad_pix_if;
  logic              valid;
  logic              ready;
  wmad_pkg::pix_t    pixel;
  logic              frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface wmad_res_if #(
  parameter int COL_W = 12
);
  logic              valid;
  logic              ready;
  wmad_pkg::pix_t    contrast;
  logic [COL_W-1:0]  center_column;
  wmad_pkg::row_t    center_row;

  modport source (output valid, contrast, center_column, center_row, input ready);
  modport sink   (input valid, contrast, center_column, center_row, output ready);
endinterface

FILE: hw/rtl/window_max_abs_difference.sv
// Top level: raster window contrast, largest absolute difference to the centre.
//
// Pixels arrive in raster order on the pix channel (valid/ready); frame_start
// on a beat restarts the column and row counts at that pixel. For every
// centre whose full (2A+1)x(2A+1) window lies in the image one beat leaves on
// the res channel with the contrast and the centre's column and row; border
// pixels give no beat. Width and aperture must be written on the cfg port only
// while the block is idle; the block does not enforce this. Out-of-range
// values are clamped.
// Throughput: one pixel per clock while the skid register is empty, set by the
// single read/write port of each line store bank and a fully pipelined compare
// tree in the cell chain.
// Reset clears the counters, the pipeline valid bits and the output buffer
// and restores width 1024 and aperture 1; line stores are not cleared.
// When res stalls, one further result is held in a skid register and then
// pix.ready drops; pix.ready depends on registered state only.
module window_max_abs_difference #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_APERTURE = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  wmad_pix_if.sink                      pix,
  wmad_res_if.source                    res,
  input  logic                          cfg_write,
  input  wmad_pkg::reg_idx_t            cfg_index,
  input  logic [wmad_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int EW        = CW + 1;
  localparam int LINES     = 2 * MAX_APERTURE;
  localparam int SIDE      = LINES + 1;
  localparam int AW        = $clog2(MAX_APERTURE + 1);
  localparam int SLOT_W    = $clog2(LINES);
  localparam int NG        = (SIDE + 2) / 3;
  localparam int MS        = 5;
  localparam int WCMP      = (EW > wmad_pkg::IMG_W_W) ? EW : wmad_pkg::IMG_W_W;
  localparam int ACMP      = (AW > wmad_pkg::APER_W) ? AW : wmad_pkg::APER_W;
  localparam int RST_WIDTH = (MAX_WIDTH < wmad_pkg::IMG_W_RESET) ?
                             MAX_WIDTH : wmad_pkg::IMG_W_RESET;

  // Configuration
  logic [EW-1:0]   eff_w;
  logic [AW-1:0]   eff_a;
  logic [WCMP-1:0] w_req;
  logic [ACMP-1:0] a_req;
  logic [EW-1:0]   w_clamp;
  logic [AW-1:0]   a_clamp;
  logic [AW:0]     span;

  // Handshake and counters
  logic              move;
  logic              acc;
  logic [CW-1:0]     col_cnt;
  wmad_pkg::row_t    row_cnt;
  logic [SLOT_W-1:0] slot_cnt;
  logic [CW-1:0]     c_use;
  wmad_pkg::row_t    r_use;
  logic [SLOT_W-1:0] slot_use;
  logic              emit0;

  // First stage
  logic              v1;
  wmad_pkg::pix_t    px1;
  logic [SLOT_W-1:0] slot1;
  logic              emit1;
  logic [CW-1:0]     ccol1;
  wmad_pkg::row_t    crow1;
  wmad_pkg::pix_t    rdata [LINES];

  // Window
  wmad_pkg::cell_ctrl_t ctrl;
  wmad_pkg::pix_t    newcol [SIDE];
  wmad_pkg::pix_t    win    [SIDE][SIDE];
  wmad_pkg::pix_t    cmax   [SIDE];
  wmad_pkg::pix_t    cpad   [3*NG];
  wmad_pkg::pix_t    centre;
  wmad_pkg::pix_t    centre_next;
  logic [SIDE-1:0]   row_en;
  logic [SIDE-1:0]   col_en;

  // Result pipeline
  logic              mv   [MS];
  logic [CW-1:0]     mcol [MS];
  wmad_pkg::row_t    mrow [MS];
  wmad_pkg::pix_t    cgrp [NG];
  wmad_pkg::pix_t    fin;
  logic              push;
  logic              pop;

  // Output buffer and skid
  logic              ov;
  wmad_pkg::pix_t    oc;
  logic [CW-1:0]     ocol;
  wmad_pkg::row_t    orow;
  logic              skid_v;
  wmad_pkg::pix_t    sc;
  logic [CW-1:0]     scol;
  wmad_pkg::row_t    srow;

  // Clamp configuration values
  always_comb begin
    w_req = WCMP'(cfg_data[wmad_pkg::IMG_W_W-1:0]);
    a_req = ACMP'(cfg_data[wmad_pkg::APER_W-1:0]);
    if (w_req == '0) begin
      w_clamp = EW'(1);
    end else if (w_req > WCMP'(MAX_WIDTH)) begin
      w_clamp = EW'(MAX_WIDTH);
    end else begin
      w_clamp = EW'(w_req);
    end
    if (a_req == '0) begin
      a_clamp = AW'(1);
    end else if (a_req > ACMP'(MAX_APERTURE)) begin
      a_clamp = AW'(MAX_APERTURE);
    end else begin
      a_clamp = AW'(a_req);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= EW'(RST_WIDTH);
      eff_a <= AW'(wmad_pkg::APER_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        wmad_pkg::REG_IMAGE_WIDTH: eff_w <= w_clamp;
        wmad_pkg::REG_APERTURE:    eff_a <= a_clamp;
      endcase
    end
  end

  assign span = {eff_a, 1'b0};

  // Whole pipeline advances unless the skid register holds a beat
  assign move      = !skid_v;
  assign pix.ready = move;
  assign acc       = pix.valid && move;

  // Position of the incoming pixel
  always_comb begin
    c_use    = pix.frame_start ? '0 : col_cnt;
    r_use    = pix.frame_start ? '0 : row_cnt;
    slot_use = pix.frame_start ? '0 : slot_cnt;
    emit0    = (32'(c_use) >= 32'(span)) && (32'(r_use) >= 32'(span));
  end

  // Advance column, row and line slot on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      slot_cnt <= '0;
    end else if (acc) begin
      if (32'(c_use) + 32'd1 >= 32'(eff_w)) begin
        col_cnt <= '0;
        if (r_use != wmad_pkg::ROW_MAX) begin
          row_cnt  <= r_use + 1'b1;
          slot_cnt <= (slot_use == SLOT_W'(LINES - 1)) ? '0 : slot_use + 1'b1;
        end else begin
          row_cnt  <= r_use;
          slot_cnt <= slot_use;
        end
      end else begin
        col_cnt  <= c_use + 1'b1;
        row_cnt  <= r_use;
        slot_cnt <= slot_use;
      end
    end
  end

  wmad_lbuf #(
    .LINES  (LINES),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW),
    .SLOT_W (SLOT_W)
  ) u_lbuf (
    .clk   (clk),
    .en    (acc),
    .addr  (c_use),
    .slot  (slot_use),
    .wdata (pix.pixel),
    .rdata (rdata)
  );

  // Hold the accepted beat while the line store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (move) begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px1   <= pix.pixel;
      slot1 <= slot_use;
      emit1 <= emit0;
      ccol1 <= CW'(32'(c_use) - 32'(eff_a));
      crow1 <= wmad_pkg::row_t'(32'(r_use) - 32'(eff_a));
    end
  end

  // Build the new column: current pixel over the stored rows above it
  always_comb begin
    int idx;
    idx = 0;
    newcol[0] = px1;
    for (int k = 1; k < SIDE; k++) begin
      idx = int'(slot1) + LINES - k;
      if (idx >= LINES) begin
        idx = idx - LINES;
      end
      newcol[k] = rdata[idx[SLOT_W-1:0]];
    end
  end

  // Window masks and centre taken from the column that shifts into place
  always_comb begin
    centre_next = '0;
    for (int i = 0; i < SIDE; i++) begin
      row_en[i] = (32'(i) <= 32'(span));
      col_en[i] = (32'(i) <= 32'(span));
    end
    for (int d = 0; d < SIDE; d++) begin
      for (int k = 0; k < SIDE; k++) begin
        if ((d + 1 == int'(eff_a)) && (k == int'(eff_a))) begin
          centre_next = win[d][k];
        end
      end
    end
  end

  assign ctrl.shift = move && v1;
  assign ctrl.adv   = move;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      centre <= centre_next;
    end
  end

  // Chain of window cells, column 0 nearest the input
  for (genvar d = 0; d < SIDE; d++) begin : g_cell
    if (d == 0) begin : g_head
      wmad_cell #(.SIDE(SIDE)) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .row_en  (row_en),
        .col_en  (col_en[d]),
        .centre  (centre),
        .col_in  (newcol),
        .col_out (win[d]),
        .col_max (cmax[d])
      );
    end else begin : g_body
      wmad_cell #(.SIDE(SIDE)) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .row_en  (row_en),
        .col_en  (col_en[d]),
        .centre  (centre),
        .col_in  (win[d-1]),
        .col_out (win[d]),
        .col_max (cmax[d])
      );
    end
  end

  // Carry centre position alongside the compare tree
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MS; i++) begin
        mv[i] <= 1'b0;
      end
    end else if (move) begin
      mv[0] <= v1 && emit1;
      for (int i = 1; i < MS; i++) begin
        mv[i] <= mv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      mcol[0] <= ccol1;
      mrow[0] <= crow1;
      for (int i = 1; i < MS; i++) begin
        mcol[i] <= mcol[i-1];
        mrow[i] <= mrow[i-1];
      end
    end
  end

  // Reduce column maxima across the cells in two steps
  always_comb begin
    for (int i = 0; i < 3*NG; i++) begin
      cpad[i] = (i < SIDE) ? cmax[i] : '0;
    end
    fin = '0;
    for (int g = 0; g < NG; g++) begin
      fin = wmad_pkg::pix_max(fin, cgrp[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int g = 0; g < NG; g++) begin
        cgrp[g] <= wmad_pkg::pix_max(wmad_pkg::pix_max(cpad[3*g], cpad[3*g+1]),
                                     cpad[3*g+2]);
      end
    end
  end

  assign push = move && mv[MS-1];
  assign pop  = ov && res.ready;

  // Output register with skid: control
  always_ff @(posedge clk) begin
    if (rst) begin
      ov     <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (!ov || pop) begin
      ov <= push;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  // Output register with skid: payload
  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        oc   <= sc;
        ocol <= scol;
        orow <= srow;
      end
    end else if (!ov || pop) begin
      if (push) begin
        oc   <= fin;
        ocol <= mcol[MS-1];
        orow <= mrow[MS-1];
      end
    end else if (push) begin
      sc   <= fin;
      scol <= mcol[MS-1];
      srow <= mrow[MS-1];
    end
  end

  assign res.valid         = ov;
  assign res.contrast      = oc;
  assign res.center_column = ocol;
  assign res.center_row    = orow;

endmodule

FILE: hw/rtl/wmad_lbuf.sv
// Line store: one bank per stored row, read at the current column, one bank written.
module wmad_lbuf #(
  parameter int LINES  = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int SLOT_W = 3
) (
  input  logic                clk,
  input  logic                en,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [SLOT_W-1:0]   slot,
  input  wmad_pkg::pix_t      wdata,
  output wmad_pkg::pix_t      rdata [LINES]
);

  for (genvar k = 0; k < LINES; k++) begin : g_bank
    wmad_pkg::pix_t mem [DEPTH];
    wmad_pkg::pix_t rd;

    // Read old contents and write the new pixel into the current row's bank
    always_ff @(posedge clk) begin
      if (en) begin
        rd <= mem[addr];
        if (slot == SLOT_W'(k)) begin
          mem[addr] <= wdata;
        end
      end
    end

    assign rdata[k] = rd;
  end

endmodule

FILE: hw/rtl/wmad_cell.sv
// Window cell: holds one window column and reduces its differences to the centre.
module wmad_cell #(
  parameter int SIDE = 9
) (
  input  logic                 clk,
  input  wmad_pkg::cell_ctrl_t ctrl,
  input  logic [SIDE-1:0]      row_en,
  input  logic                 col_en,
  input  wmad_pkg::pix_t       centre,
  input  wmad_pkg::pix_t       col_in  [SIDE],
  output wmad_pkg::pix_t       col_out [SIDE],
  output wmad_pkg::pix_t       col_max
);

  localparam int NG = (SIDE + 2) / 3;

  wmad_pkg::pix_t col      [SIDE];
  wmad_pkg::pix_t diff     [SIDE];
  wmad_pkg::pix_t dpad     [3*NG];
  wmad_pkg::pix_t grp      [NG];
  wmad_pkg::pix_t grp_next [NG];
  wmad_pkg::pix_t mx;
  wmad_pkg::pix_t mx_next;

  // Take the neighbour's column on every shift
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // Pad the differences to whole groups of three
  always_comb begin
    for (int i = 0; i < 3*NG; i++) begin
      dpad[i] = (i < SIDE) ? diff[i] : '0;
    end
  end

  // Reduce each group of three, then the groups
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_next[g] = wmad_pkg::pix_max(wmad_pkg::pix_max(dpad[3*g], dpad[3*g+1]),
                                      dpad[3*g+2]);
    end
    mx_next = '0;
    for (int g = 0; g < NG; g++) begin
      mx_next = wmad_pkg::pix_max(mx_next, grp[g]);
    end
  end

  // Advance differences, group maxima and column maximum
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      for (int k = 0; k < SIDE; k++) begin
        diff[k] <= (row_en[k] && col_en) ? wmad_pkg::abs_diff(centre, col[k]) : '0;
      end
      grp <= grp_next;
      mx  <= mx_next;
    end
  end

  assign col_max = mx;

endmodule

FILE: hw/rtl/wmad_checker.sv
// Port-level checks for the window contrast block, bound to the top level.
module wmad_checker #(
  parameter int COL_W = 12
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 pix_valid,
  input logic                 pix_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input wmad_pkg::pix_t       res_contrast,
  input logic [COL_W-1:0]     res_center_column,
  input wmad_pkg::row_t       res_center_row
);

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat valid after reset");

  // A stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_contrast) &&
      $stable(res_center_column) && $stable(res_center_row))
    else $error("stalled result beat changed");

  // Input back-pressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> $past(res_valid && !res_ready))
    else $error("pixel channel stalled without an output stall");

  // A centre never sits on the top row or left column
  a_centre_inside: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_center_column != '0) && (res_center_row != '0))
    else $error("result centre on the image border");

endmodule

bind window_max_abs_difference wmad_checker #(
  .COL_W ($clog2(MAX_WIDTH))
) u_checker (
  .clk               (clk),
  .rst               (rst),
  .pix_valid         (pix.valid),
  .pix_ready         (pix.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_contrast      (res.contrast),
  .res_center_column (res.center_column),
  .res_center_row    (res.center_row)
);
